/* hw/rtl/tle_pkg.sv */
// shared types, codes and constants for the terminal line editor
`default_nettype none

package tle_pkg;

    localparam int LINE_DEPTH_DEF = 32;

    // result kinds
    localparam logic [2:0] KIND_ECHO = 3'd0;
    localparam logic [2:0] KIND_LINE = 3'd1;
    localparam logic [2:0] KIND_INTR = 3'd2;
    localparam logic [2:0] KIND_STAT = 3'd3;
    localparam logic [2:0] KIND_EOF  = 3'd4;

    // register indexes, taken from paddr[3:2]
    localparam logic [1:0] REG_ECHO_ENABLE  = 2'd0;
    localparam logic [1:0] REG_LINE_MODE    = 2'd1;
    localparam logic [1:0] REG_SIGNAL_GROUP = 2'd2;

    // byte codes
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CTL_C = 8'h03;
    localparam logic [7:0] CH_CTL_X = 8'h18;
    localparam logic [7:0] CH_CTL_T = 8'h14;
    localparam logic [7:0] CH_CTL_D = 8'h04;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_CARET = 8'h5E;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ECHO,
        ST_SIG,
        ST_LREAD,
        ST_LEMIT
    } tle_state_t;

    typedef struct packed {
        logic        echo_enable;
        logic        line_mode;
        logic [15:0] signal_group;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic emit_echo;
        logic emit_sig;
        logic rd_issue;
        logic emit_line;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic       out_free;
        logic [1:0] cls_echo_n;
        logic       cls_sig;
        logic       cls_deliver;
        logic       echo_last;
        logic       deliver_pend;
        logic       line_last;
    } sts_t;

endpackage

`default_nettype wire

/* hw/rtl/tle_regs.sv */
// configuration registers behind the apb port
`default_nettype none

module tle_regs
    import tle_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output cfg_t             cfg
);

    logic        echo_enable_reg;
    logic        line_mode_reg;
    logic [15:0] signal_group_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_enable_reg  <= 1'b1;
            line_mode_reg    <= 1'b1;
            signal_group_reg <= 16'd0;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_ECHO_ENABLE:  echo_enable_reg  <= pwdata[0];
                REG_LINE_MODE:    line_mode_reg    <= pwdata[0];
                REG_SIGNAL_GROUP: signal_group_reg <= pwdata[15:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_ECHO_ENABLE:  prdata = {31'd0, echo_enable_reg};
            REG_LINE_MODE:    prdata = {31'd0, line_mode_reg};
            REG_SIGNAL_GROUP: prdata = {16'd0, signal_group_reg};
            default:          prdata = 32'd0;
        endcase
    end

    assign cfg.echo_enable  = echo_enable_reg;
    assign cfg.line_mode    = line_mode_reg;
    assign cfg.signal_group = signal_group_reg;

endmodule

`default_nettype wire

/* hw/rtl/tle_ctrl.sv */
// sequencing state machine for the line editor
`default_nettype none

module tle_ctrl
    import tle_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  sts_t      sts,
    output cmd_t      cmd
);

    tle_state_t state_reg;
    tle_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (sts.cls_sig)
                        state_next = ST_SIG;
                    else if (sts.cls_echo_n != 2'd0)
                        state_next = ST_ECHO;
                    else if (sts.cls_deliver)
                        state_next = ST_LREAD;
                end
            end
            ST_ECHO:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_echo = 1'b1;
                    if (sts.echo_last)
                        state_next = sts.deliver_pend ? ST_LREAD : ST_IDLE;
                end
            end
            ST_SIG:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_sig = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_LREAD:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_LEMIT;
            end
            ST_LEMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_line = 1'b1;
                    state_next    = sts.line_last ? ST_IDLE : ST_LREAD;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/tle_dpath.sv */
// byte classification, line store, result sequencing registers and output register
`default_nettype none

module tle_dpath
    import tle_pkg::*;
#(
    parameter int LINE_DEPTH = LINE_DEPTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  cfg_t             cfg,
    input  cmd_t             cmd,
    output sts_t             sts,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        out_ready,
    output logic             out_valid,
    output logic      [2:0]  out_kind,
    output logic      [7:0]  out_data,
    output logic      [15:0] out_group,
    output logic             out_last
);

    localparam int ADDR_W = $clog2(LINE_DEPTH);
    localparam int CNT_W  = $clog2(LINE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LINE_DEPTH);

    logic [7:0]        line_mem [LINE_DEPTH];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [ADDR_W-1:0] rd_idx_reg;
    logic [ADDR_W-1:0] rd_idx_next;
    logic [7:0]        rd_data_reg;

    logic [7:0]        echo0_reg;
    logic [7:0]        echo1_reg;
    logic [7:0]        echo2_reg;
    logic [1:0]        echo_n_reg;
    logic [1:0]        echo_idx_reg;
    logic [1:0]        echo_idx_next;
    logic              deliver_reg;
    logic [2:0]        sig_kind_reg;
    logic [15:0]       sig_group_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [2:0]        out_kind_reg;
    logic [7:0]        out_data_reg;
    logic [15:0]       out_group_reg;
    logic              out_last_reg;

    // classification of the incoming byte
    logic        c_wr;
    logic [7:0]  c_wr_byte;
    logic        c_dec;
    logic [7:0]  c_e0;
    logic [7:0]  c_e1;
    logic [7:0]  c_e2;
    logic [1:0]  c_n;
    logic        c_sig;
    logic [2:0]  c_sig_kind;
    logic [15:0] c_sig_group;
    logic        c_deliver;
    logic        not_full;
    logic        not_empty;
    logic        store_en;
    logic        line_last;
    logic        echo_last;
    logic        emit_any;
    logic [7:0]  echo_sel;

    assign not_full  = count_reg < DEPTH_C;
    assign not_empty = count_reg != '0;

    always_comb
    begin
        c_wr        = 1'b0;
        c_wr_byte   = rx_byte;
        c_dec       = 1'b0;
        c_e0        = CH_CR;
        c_e1        = CH_LF;
        c_e2        = CH_BS;
        c_n         = 2'd0;
        c_sig       = 1'b0;
        c_sig_kind  = KIND_INTR;
        c_sig_group = cfg.signal_group;
        c_deliver   = 1'b0;
        if (rx_byte == CH_CR || rx_byte == CH_LF)
        begin
            c_wr      = 1'b1;
            c_wr_byte = CH_LF;
            c_n       = 2'd2;
            c_deliver = 1'b1;
        end
        else if (rx_byte == CH_CTL_C || rx_byte == CH_CTL_X)
        begin
            c_sig = 1'b1;
        end
        else if (rx_byte == CH_CTL_T)
        begin
            c_sig      = 1'b1;
            c_sig_kind = KIND_STAT;
        end
        else if (rx_byte == CH_CTL_D)
        begin
            if (not_empty)
                c_deliver = 1'b1;
            else
            begin
                c_sig       = 1'b1;
                c_sig_kind  = KIND_EOF;
                c_sig_group = 16'd0;
            end
        end
        else if (!cfg.line_mode)
        begin
            c_wr      = 1'b1;
            c_n       = 2'd2;
            c_deliver = 1'b1;
        end
        else if (rx_byte >= CH_SP && rx_byte <= CH_TILDE)
        begin
            // a printable byte that does not fit is neither stored nor echoed
            if (not_full)
            begin
                c_wr = 1'b1;
                c_e0 = rx_byte;
                c_n  = 2'd1;
            end
        end
        else if (rx_byte == CH_DEL)
        begin
            if (not_empty)
            begin
                c_dec = 1'b1;
                c_e0  = CH_BS;
                c_e1  = CH_SP;
                c_e2  = CH_BS;
                c_n   = 2'd3;
            end
        end
        else
        begin
            c_e0 = CH_CARET;
            c_e1 = rx_byte + CH_AT;
            c_n  = 2'd2;
        end
        if (!cfg.echo_enable)
            c_n = 2'd0;
    end

    assign store_en  = cmd.accept && c_wr && not_full;
    assign line_last = CNT_W'(rd_idx_reg) == (count_reg - CNT_W'(1));
    assign echo_last = echo_idx_reg == (echo_n_reg - 2'd1);
    assign emit_any  = cmd.emit_echo || cmd.emit_sig || cmd.emit_line;

    always_ff @(posedge clk)
    begin
        if (store_en)
            line_mem[count_reg[ADDR_W-1:0]] <= c_wr_byte;
        if (cmd.rd_issue)
            rd_data_reg <= line_mem[rd_idx_reg];
    end

    always_comb
    begin
        count_next = count_reg;
        if (store_en)
            count_next = count_reg + CNT_W'(1);
        else if (cmd.accept && c_dec)
            count_next = count_reg - CNT_W'(1);
        else if (cmd.emit_line && line_last)
            count_next = '0;
    end

    always_comb
    begin
        rd_idx_next = rd_idx_reg;
        if (cmd.emit_line)
            rd_idx_next = line_last ? '0 : rd_idx_reg + ADDR_W'(1);
    end

    always_comb
    begin
        echo_idx_next = echo_idx_reg;
        if (cmd.accept)
            echo_idx_next = 2'd0;
        else if (cmd.emit_echo)
            echo_idx_next = echo_idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            echo_idx_reg  <= 2'd0;
            echo_n_reg    <= 2'd0;
            deliver_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            echo_idx_reg  <= echo_idx_next;
            out_valid_reg <= out_valid_next;
            if (cmd.accept)
            begin
                echo_n_reg  <= c_n;
                deliver_reg <= c_deliver;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            echo0_reg     <= c_e0;
            echo1_reg     <= c_e1;
            echo2_reg     <= c_e2;
            sig_kind_reg  <= c_sig_kind;
            sig_group_reg <= c_sig_group;
        end
    end

    always_comb
    begin
        case (echo_idx_reg)
            2'd0:    echo_sel = echo0_reg;
            2'd1:    echo_sel = echo1_reg;
            default: echo_sel = echo2_reg;
        endcase
    end

    // output register, refilled in the cycle it is taken
    assign out_valid_next = emit_any ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.emit_echo)
        begin
            out_kind_reg  <= KIND_ECHO;
            out_data_reg  <= echo_sel;
            out_group_reg <= 16'd0;
            out_last_reg  <= echo_last && !deliver_reg;
        end
        else if (cmd.emit_sig)
        begin
            out_kind_reg  <= sig_kind_reg;
            out_data_reg  <= 8'd0;
            out_group_reg <= sig_group_reg;
            out_last_reg  <= 1'b1;
        end
        else if (cmd.emit_line)
        begin
            out_kind_reg  <= KIND_LINE;
            out_data_reg  <= rd_data_reg;
            out_group_reg <= 16'd0;
            out_last_reg  <= line_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_data  = out_data_reg;
    assign out_group = out_group_reg;
    assign out_last  = out_last_reg;

    assign sts.out_free     = !out_valid_reg || out_ready;
    assign sts.cls_echo_n   = c_n;
    assign sts.cls_sig      = c_sig;
    assign sts.cls_deliver  = c_deliver;
    assign sts.echo_last    = echo_last;
    assign sts.deliver_pend = deliver_reg;
    assign sts.line_last    = line_last;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("line count beyond store depth");

    a_emit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.emit_echo, cmd.emit_sig, cmd.emit_line, cmd.accept}))
        else $error("more than one result source in a cycle");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !emit_any)
        else $error("result written over a waiting result");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_line && line_last) |=> (count_reg == '0 && rd_idx_reg == '0))
        else $error("store not cleared after delivery");

    a_deliver_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_issue |-> not_empty)
        else $error("delivery read from an empty store");

endmodule

`default_nettype wire

/* hw/rtl/tty_line_editor_top.sv */
// top level of the terminal line editor: apb registers, controller and datapath
`default_nettype none

// Terminal line editor. Received bytes enter on the s_ stream, one at a time; every
// result (echo byte, delivered line byte, signal or end of file) leaves on the m_ stream,
// with tlast on the final result of each input byte. A byte is taken while the controller
// is idle; after that, each echo or signal result goes straight into the output register
// and each delivered line byte is first read from the line store into a register, then
// written to the output register; an output write waits while a result is not taken.
// The next byte is accepted once every result of the previous one has entered the output
// register. The line store needs no clearing after reset; only entries below the fill
// count are ever read.
module tty_line_editor_top
    import tle_pkg::*;
#(
    parameter int LINE_DEPTH = LINE_DEPTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // s_tdata: rx_byte[7:0]
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,
    // m_tdata: data[7:0], group[23:8]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata,
    // m_tuser: kind[2:0]
    output logic      [2:0]  m_tuser,
    output logic             m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    cfg_t        cfg;
    cmd_t        cmd;
    sts_t        sts;
    logic [7:0]  out_data;
    logic [15:0] out_group;

    tle_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tle_dpath #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .sts       (sts),
        .rx_byte   (s_tdata),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_kind  (m_tuser),
        .out_data  (out_data),
        .out_group (out_group),
        .out_last  (m_tlast)
    );

    assign m_tdata = {out_group, out_data};

endmodule

`default_nettype wire

/* tb/sv/tty_line_editor_top_tb.sv */
// self-checking testbench for the terminal line editor: streamed bytes, apb setup, result checks
module tty_line_editor_top_tb
    import tle_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = LINE_DEPTH_DEF;
    localparam int DRAIN       = 2 * DEPTH + 12;
    localparam int HOLD_CYCLES = 300;
    localparam int LIMIT       = 500000;

    // index that decodes to no register
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data;
        logic [15:0] grp;
        logic        last;
    } result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'h0;
    logic [31:0] pwdata = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    tty_line_editor_top #(.LINE_DEPTH(DEPTH)) dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 clk = ~clk;

    // bytes waiting to be sent and results still owed by the block
    logic [7:0]  rx_bytes[$];
    result_t     awaited[$];
    result_t     step_out[$];
    int unsigned rx_pushed = 0;
    int unsigned rx_taken = 0;
    int unsigned errors = 0;
    int unsigned cycles = 0;
    logic        s_hs = 1'b0;

    int send_idle = 0;
    int recv_stall = 0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;

    // mirror of the editor state
    logic [7:0]  line_buf [DEPTH];
    int unsigned line_fill = 0;
    logic        cfg_echo = 1'b1;
    logic        cfg_line = 1'b1;
    logic [15:0] cfg_group = 16'h0;

    function automatic void put(logic [2:0] k, logic [7:0] d, logic [15:0] g);
        result_t r;
        r.kind = k;
        r.data = d;
        r.grp  = g;
        r.last = 1'b0;
        step_out.push_back(r);
    endfunction

    function automatic void echo(logic [7:0] d);
        if (cfg_echo)
            put(KIND_ECHO, d, 16'h0);
    endfunction

    function automatic void keep(logic [7:0] d);
        if (line_fill < DEPTH)
        begin
            line_buf[line_fill] = d;
            line_fill++;
        end
    endfunction

    function automatic void flush_line();
        for (int unsigned i = 0; i < line_fill; i++)
            put(KIND_LINE, line_buf[i], 16'h0);
        line_fill = 0;
    endfunction

    function automatic void edit_byte(logic [7:0] b);
        step_out.delete();
        if (b == CH_CR || b == CH_LF)
        begin
            keep(CH_LF);
            echo(CH_CR);
            echo(CH_LF);
            flush_line();
        end
        else if (b == CH_CTL_C || b == CH_CTL_X)
        begin
            put(KIND_INTR, 8'h00, cfg_group);
        end
        else if (b == CH_CTL_T)
        begin
            put(KIND_STAT, 8'h00, cfg_group);
        end
        else if (b == CH_CTL_D)
        begin
            if (line_fill > 0)
                flush_line();
            else
                put(KIND_EOF, 8'h00, 16'h0);
        end
        else if (!cfg_line)
        begin
            keep(b);
            echo(CH_CR);
            echo(CH_LF);
            flush_line();
        end
        else if (b >= CH_SP && b <= CH_TILDE)
        begin
            // a printable byte that does not fit is neither stored nor echoed
            if (line_fill < DEPTH)
            begin
                keep(b);
                echo(b);
            end
        end
        else if (b == CH_DEL)
        begin
            if (line_fill > 0)
            begin
                line_fill--;
                echo(CH_BS);
                echo(CH_SP);
                echo(CH_BS);
            end
        end
        else
        begin
            echo(CH_CARET);
            echo(8'(b + CH_AT));
        end
        if (step_out.size() > 0)
            step_out[step_out.size() - 1].last = 1'b1;
        foreach (step_out[i])
            awaited.push_back(step_out[i]);
    endfunction

    // monitor: accepted requests, register writes and results
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        got.kind = m_tuser;
        got.data = m_tdata[7:0];
        got.grp  = m_tdata[23:8];
        got.last = m_tlast;
        s_hs <= rst_n && s_tvalid && s_tready;
        if (rst_n && psel && penable && pwrite && pready)
        begin
            case (paddr[3:2])
                REG_ECHO_ENABLE:  cfg_echo = pwdata[0];
                REG_LINE_MODE:    cfg_line = pwdata[0];
                REG_SIGNAL_GROUP: cfg_group = pwdata[15:0];
                default: ;
            endcase
        end
        if (rst_n && s_tvalid && s_tready)
        begin
            edit_byte(s_tdata);
            rx_taken++;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (awaited.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: kind %0d data %h group %h last %b",
                             got.kind, got.data, got.grp, got.last);
            end
            else
            begin
                want = awaited.pop_front();
                if (got !== want)
                begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch: expected kind %0d data %h group %h last %b,",
                                  " got kind %0d data %h group %h last %b"},
                                 want.kind, want.data, want.grp, want.last,
                                 got.kind, got.data, got.grp, got.last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // byte sender
    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (s_tvalid && !s_hs)
            ;
        else if (rx_bytes.size() != 0 && $urandom_range(99) >= send_idle)
        begin
            s_tvalid <= 1'b1;
            s_tdata  <= rx_bytes.pop_front();
        end
        else
            s_tvalid <= 1'b0;
    end

    // result receiver, with one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall);
    end

    task automatic set_idling(input idle_mode_t m);
        case (m)
            IDLE_NONE:
            begin
                send_idle = 0;  recv_stall = 0;
            end
            IDLE_SEND:
            begin
                send_idle = 60; recv_stall = 0;
            end
            IDLE_RECV:
            begin
                send_idle = 0;  recv_stall = 60;
            end
            IDLE_BOTH:
            begin
                send_idle = 20; recv_stall = 20;
            end
        endcase
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // upper bits of each write are random and must be ignored
    task automatic configure(input logic e, input logic l, input logic [15:0] g);
        apb_write(REG_ECHO_ENABLE, ($urandom & 32'hFFFF_FFFE) | e);
        apb_write(REG_LINE_MODE, ($urandom & 32'hFFFF_FFFE) | l);
        apb_write(REG_SIGNAL_GROUP, ($urandom & 32'hFFFF_0000) | g);
    endtask

    task automatic send(input logic [7:0] b);
        rx_bytes.push_back(b);
        rx_pushed++;
    endtask

    // a typed line: mostly printable, some erases and noise, then usually an end
    task automatic send_line(input int len);
        int pick;
        for (int i = 0; i < len; i++)
        begin
            pick = $urandom_range(19);
            if (pick < 2)
                send(CH_DEL);
            else if (pick == 2)
                send(8'($urandom_range(255)));
            else
                send(8'($urandom_range(CH_SP, CH_TILDE)));
        end
        pick = $urandom_range(19);
        if (pick < 7)
            send(CH_CR);
        else if (pick < 14)
            send(CH_LF);
        else if (pick < 17)
            send(CH_CTL_D);
        else if (pick == 17)
            send($urandom_range(1) ? CH_CTL_C : CH_CTL_X);
        else if (pick == 18)
            send(CH_CTL_T);
    endtask

    task automatic send_traffic(input int n);
        int unsigned target;
        target = rx_pushed + n;
        while (rx_pushed < target)
        begin
            if ($urandom_range(9) < 8)
                send_line(($urandom_range(7) == 0) ? $urandom_range(30, 40)
                                                   : $urandom_range(0, 12));
            else
                send(8'($urandom_range(255)));
        end
    endtask

    // sender pause: everything accepted, every result back, then a further drain wait
    task automatic wait_idle();
        do
            @(negedge clk);
        while (rx_taken != rx_pushed || awaited.size() != 0);
        repeat (DRAIN) @(negedge clk);
    endtask

    initial
    begin
        logic [7:0] directed[$];
        directed = '{CH_SP, CH_TILDE, 8'h41, CH_DEL, 8'h00, 8'hFF, 8'h80, 8'h1F,
                     CH_CTL_C, CH_CTL_X, CH_CTL_T, CH_CTL_D, CH_CTL_D, CH_DEL,
                     CH_CR, 8'h61, CH_LF};
        set_idling(IDLE_NONE);
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        configure(1'b1, 1'b1, 16'hFFFF);
        foreach (directed[i])
            send(directed[i]);
        wait_idle();

        // long receiver hold while a full-store line keeps coming
        configure(1'b1, 1'b1, 16'($urandom));
        apb_write(REG_UNUSED, $urandom);
        hold_req = 1'b1;
        for (int i = 0; i < 40; i++)
            send(8'($urandom_range(CH_SP, CH_TILDE)));
        send(CH_CR);
        send_traffic(40);
        wait_idle();

        configure(1'b0, 1'b1, 16'h0000);
        set_idling(IDLE_SEND);
        send_traffic(30);
        wait_idle();

        configure(1'b1, 1'b0, 16'($urandom));
        set_idling(IDLE_RECV);
        send_traffic(20);
        wait_idle();

        configure(1'b0, 1'b0, 16'($urandom));
        set_idling(IDLE_BOTH);
        send_traffic(20);
        wait_idle();

        configure(1'b1, 1'b1, 16'($urandom));
        send_traffic(30);
        wait_idle();

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/tle_pkg.sv
hw/rtl/tle_regs.sv
hw/rtl/tle_ctrl.sv
hw/rtl/tle_dpath.sv
hw/rtl/tty_line_editor_top.sv
tb/sv/tty_line_editor_top_tb.sv
